[hdl/mafh_pkg.sv]
`timescale 1ns / 1ps

package mafh_pkg;

   // queue between the classify front and the length back end
   localparam int unsigned QueueDepthDefault = 4;

   // field widths
   localparam int unsigned HdrW     = 32;
   localparam int unsigned KbpsW    = 9;
   localparam int unsigned HzW      = 16;
   localparam int unsigned LenW     = 11;
   localparam int unsigned MultW    = 13;
   localparam int unsigned RecipW   = 20;
   localparam int unsigned DivW     = 9;
   localparam int unsigned NumW     = 22;
   localparam int unsigned QuotW    = 13;
   localparam int unsigned RecipShift = 24;
   localparam int unsigned RspDataW = 48;

   localparam logic [LenW-1:0] LenMax = 11'd2047;

   // sync pattern
   localparam logic [7:0] SyncByte    = 8'hFF;
   localparam logic [2:0] SyncTopBits = 3'b111;

   // version codes
   localparam logic [1:0] VER_MPEG25 = 2'd0;
   localparam logic [1:0] VER_RSV    = 2'd1;
   localparam logic [1:0] VER_MPEG2  = 2'd2;
   localparam logic [1:0] VER_MPEG1  = 2'd3;

   // layer codes
   localparam logic [1:0] LAYER_RSV = 2'd0;
   localparam logic [1:0] LAYER_3   = 2'd1;
   localparam logic [1:0] LAYER_2   = 2'd2;
   localparam logic [1:0] LAYER_1   = 2'd3;

   // special index codes
   localparam logic [3:0] BR_FREE   = 4'd0;
   localparam logic [3:0] BR_BAD    = 4'd15;
   localparam logic [1:0] FS_BAD    = 2'd3;
   localparam logic [1:0] MODE_MONO = 2'd3;

   localparam logic [1:0] CH_MONO   = 2'd1;
   localparam logic [1:0] CH_STEREO = 2'd2;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_SYNC     = 3'd1,
      ST_RSV_VERSION = 3'd2,
      ST_RSV_LAYER   = 3'd3,
      ST_BAD_BITRATE = 3'd4,
      ST_BAD_RATE    = 3'd5,
      ST_FREE_FORMAT = 3'd6
   } status_type;

   // bit rate tables: V1 L1, V1 L2, V1 L3, V2 L1, V2 L2/L3
   localparam logic [KbpsW-1:0] RATE_TAB [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   // sample rate tables: MPEG1, MPEG2, MPEG2.5
   localparam logic [HzW-1:0] FS_TAB [3][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000,  16'd0}
   };

   // decoded fields that go out unchanged
   typedef struct packed {
      status_type         status;
      logic [1:0]         version_code;
      logic [1:0]         layer_code;
      logic [KbpsW-1:0]   bitrate_kbps;
      logic [HzW-1:0]     sample_rate_hz;
      logic               padding_bit;
      logic [1:0]         channel_count;
   } hdr_fields_type;

   // length = floor(kbps * mult / divisor), via reciprocal
   typedef struct packed {
      logic [MultW-1:0]  mult;
      logic [RecipW-1:0] recip;
      logic [DivW-1:0]   divisor;
   } div_param_type;

   typedef struct packed {
      hdr_fields_type fields;
      logic           len_en;
      logic           layer1;
      div_param_type  div;
   } hdr_entry_type;

   // forward side of a word handoff
   typedef struct packed {
      logic          valid;
      hdr_entry_type entry;
   } hdr_push_type;

   // 1000 / hz folded into a small ratio per sample rate family
   function automatic div_param_type div_params(logic [1:0] ver, logic [1:0] lay,
                                                logic [1:0] fs_idx);
      div_param_type p;
      logic [7:0]       slots;
      logic [MultW-1:0] m;
      if (lay == LAYER_1) begin
         slots = 8'd12;
      end else if (lay == LAYER_3 && ver != VER_MPEG1) begin
         slots = 8'd72;
      end else begin
         slots = 8'd144;
      end
      m = {5'd0, slots};
      // half and quarter rate versions
      if (ver == VER_MPEG2) begin
         m = m << 1;
      end else if (ver != VER_MPEG1) begin
         m = m << 2;
      end
      case (fs_idx)
         2'd0: begin
            p.mult    = MultW'(m * 13'd10);
            p.recip   = 20'd38043;
            p.divisor = 9'd441;
         end
         2'd1: begin
            p.mult    = m;
            p.recip   = 20'd349525;
            p.divisor = 9'd48;
         end
         default: begin
            p.mult    = m;
            p.recip   = 20'd524288;
            p.divisor = 9'd32;
         end
      endcase
      return p;
   endfunction

endpackage

[hdl/mafh_front.sv]
`timescale 1ns / 1ps

module mafh_front
   import mafh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [HdrW-1:0]   req_tdata,
   output hdr_push_type      push,
   input  logic              push_ready
);

   logic [1:0]       ver;
   logic [1:0]       lay;
   logic [3:0]       br_idx;
   logic [1:0]       fs_idx;
   logic             sync;
   logic [2:0]       rate_sel;
   logic [1:0]       fs_sel;
   hdr_entry_type    entry;

   logic             f_vld_ff, f_vld_in;
   hdr_entry_type    f_entry_ff;

   // header fields
   assign ver    = req_tdata[20:19];
   assign lay    = req_tdata[18:17];
   assign br_idx = req_tdata[15:12];
   assign fs_idx = req_tdata[11:10];
   assign sync   = (req_tdata[31:24] == SyncByte) && (req_tdata[23:21] == SyncTopBits);

   // table selection
   always_comb begin
      if (ver == VER_MPEG1) begin
         rate_sel = 3'(2'd3 - lay);
      end else if (lay == LAYER_1) begin
         rate_sel = 3'd3;
      end else begin
         rate_sel = 3'd4;
      end
      if (ver == VER_MPEG1) begin
         fs_sel = 2'd0;
      end else if (ver == VER_MPEG2) begin
         fs_sel = 2'd1;
      end else begin
         fs_sel = 2'd2;
      end
   end

   // classify and look up
   always_comb begin
      entry.fields.version_code   = ver;
      entry.fields.layer_code     = lay;
      entry.fields.padding_bit    = req_tdata[9];
      entry.fields.channel_count  = (req_tdata[7:6] == MODE_MONO) ? CH_MONO : CH_STEREO;
      entry.fields.sample_rate_hz = '0;
      entry.fields.bitrate_kbps   = '0;
      if (sync && ver != VER_RSV) begin
         entry.fields.sample_rate_hz = FS_TAB[fs_sel][fs_idx];
         if (lay != LAYER_RSV) begin
            entry.fields.bitrate_kbps = RATE_TAB[rate_sel][br_idx];
         end
      end
      if (!sync) begin
         entry.fields.status = ST_NO_SYNC;
      end else if (ver == VER_RSV) begin
         entry.fields.status = ST_RSV_VERSION;
      end else if (lay == LAYER_RSV) begin
         entry.fields.status = ST_RSV_LAYER;
      end else if (br_idx == BR_BAD) begin
         entry.fields.status = ST_BAD_BITRATE;
      end else if (fs_idx == FS_BAD) begin
         entry.fields.status = ST_BAD_RATE;
      end else if (br_idx == BR_FREE) begin
         entry.fields.status = ST_FREE_FORMAT;
      end else begin
         entry.fields.status = ST_OK;
      end
      entry.len_en = (entry.fields.status == ST_OK);
      entry.layer1 = (lay == LAYER_1);
      entry.div    = div_params(ver, lay, fs_idx);
   end

   // one-word holding register
   assign req_tready = !f_vld_ff || push_ready;
   assign f_vld_in   = req_tready ? req_tvalid : f_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         f_entry_ff <= entry;
      end
   end

   assign push.valid = f_vld_ff;
   assign push.entry = f_entry_ff;

   // a good header always carries both rates
   a_ok_has_rates: assert property (@(posedge clock) disable iff (reset)
      f_vld_ff && f_entry_ff.fields.status == ST_OK |->
         f_entry_ff.fields.bitrate_kbps != '0 && f_entry_ff.fields.sample_rate_hz != '0)
      else $error("good header without bit rate or sample rate");

endmodule

[hdl/mafh_queue.sv]
`timescale 1ns / 1ps

module mafh_queue
   import mafh_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)
(
   input  logic         clock,
   input  logic         reset,
   input  hdr_push_type push,
   output logic         push_ready,
   output hdr_push_type pop,
   input  logic         pop_ready
);

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   hdr_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntFull);
   assign do_push    = push.valid && push_ready;
   assign pop.valid  = (count_ff != '0);
   assign pop.entry  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop.valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count above depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");

endmodule

[hdl/mafh_back.sv]
`timescale 1ns / 1ps

module mafh_back
   import mafh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  hdr_push_type         pop,
   output logic                 pop_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspDataW-1:0]  rsp_tdata
);

   localparam int unsigned ProdW  = NumW + RecipW;
   localparam int unsigned SlotW  = QuotW + 1;
   localparam int unsigned BytesW = SlotW + 2;

   // stage 1: numerator
   logic             s1_vld_ff;
   hdr_entry_type    s1_entry_ff;
   logic [NumW-1:0]  s1_num_ff;
   // stage 2: quotient estimate
   logic             s2_vld_ff;
   hdr_entry_type    s2_entry_ff;
   logic [NumW-1:0]  s2_num_ff;
   logic [QuotW-1:0] s2_q0_ff;
   // stage 3: back product for the remainder
   logic             s3_vld_ff;
   hdr_entry_type    s3_entry_ff;
   logic [NumW-1:0]  s3_num_ff;
   logic [QuotW-1:0] s3_q0_ff;
   logic [NumW-1:0]  s3_qd_ff;
   // output register
   logic             out_vld_ff;
   hdr_fields_type   out_fields_ff;
   logic [LenW-1:0]  out_len_ff;

   logic             out_rdy, s3_rdy, s2_rdy, s1_rdy;
   logic [ProdW-1:0] recip_prod;
   logic [NumW-1:0]  rem;
   logic [QuotW-1:0] quot;
   logic [SlotW-1:0] slots;
   logic [BytesW-1:0] bytes;
   logic [LenW-1:0]  len;

   // stall chain
   assign out_rdy   = !out_vld_ff || rsp_tready;
   assign s3_rdy    = !s3_vld_ff || out_rdy;
   assign s2_rdy    = !s2_vld_ff || s3_rdy;
   assign s1_rdy    = !s1_vld_ff || s2_rdy;
   assign pop_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= pop.valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (out_rdy) begin
            out_vld_ff <= s3_vld_ff;
         end
      end
   end

   // kbps times folded ratio
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_entry_ff <= pop.entry;
         s1_num_ff   <= NumW'(pop.entry.fields.bitrate_kbps * pop.entry.div.mult);
      end
   end

   // quotient estimate, low by at most one
   assign recip_prod = ProdW'(s1_num_ff * s1_entry_ff.div.recip);

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_entry_ff <= s1_entry_ff;
         s2_num_ff   <= s1_num_ff;
         s2_q0_ff    <= recip_prod[RecipShift +: QuotW];
      end
   end

   // estimate times divisor
   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_entry_ff <= s2_entry_ff;
         s3_num_ff   <= s2_num_ff;
         s3_q0_ff    <= s2_q0_ff;
         s3_qd_ff    <= NumW'(s2_q0_ff * s2_entry_ff.div.divisor);
      end
   end

   // correct, pad, scale layer I slots, saturate; zero length for a bad header
   always_comb begin
      rem   = s3_num_ff - s3_qd_ff;
      quot  = (rem >= NumW'(s3_entry_ff.div.divisor)) ? s3_q0_ff + 1'b1 : s3_q0_ff;
      slots = SlotW'(quot) + SlotW'(s3_entry_ff.fields.padding_bit);
      bytes = s3_entry_ff.layer1 ? {slots, 2'b00} : {2'b00, slots};
      if (!s3_entry_ff.len_en) begin
         len = '0;
      end else if (bytes > BytesW'(LenMax)) begin
         len = LenMax;
      end else begin
         len = bytes[LenW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         out_fields_ff <= s3_entry_ff.fields;
         out_len_ff    <= len;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_len_ff, out_fields_ff.channel_count,
                        out_fields_ff.padding_bit, out_fields_ff.sample_rate_hz,
                        out_fields_ff.bitrate_kbps, out_fields_ff.layer_code,
                        out_fields_ff.version_code, out_fields_ff.status};

   a_len_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_fields_ff.status != ST_OK |-> out_len_ff == '0)
      else $error("frame length given for a bad header");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s2_rdy |=> s1_vld_ff)
      else $error("stalled word dropped from first stage");

endmodule

[hdl/mpeg_audio_frame_header_decode.sv]
`timescale 1ns / 1ps
// path: front holding register, word queue, back-end stages, output register
// throughput: one header word per cycle unless stalled, set by the three-stage
// reciprocal multiply in the back end and the one-push, one-pop word queue
// reset: synchronous, active high; clears valid bits, queue pointers and count only
// each word is decoded on its own, no state carries between words

module mpeg_audio_frame_header_decode
   import mafh_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [HdrW-1:0]      req_tdata,   // header_word
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // status, version_code, layer_code, bitrate_kbps, sample_rate_hz,
   // padding_bit, channel_count, frame_bytes, zero fill
   output logic [RspDataW-1:0]  rsp_tdata
);

   hdr_push_type front_push;
   logic         front_ready;
   hdr_push_type queue_pop;
   logic         back_ready;

   // classify
   mafh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (front_push),
      .push_ready (front_ready)
   );

   // decoupling queue
   mafh_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_ready (front_ready),
      .pop        (queue_pop),
      .pop_ready  (back_ready)
   );

   // frame length
   mafh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (queue_pop),
      .pop_ready  (back_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
